@@ rtl/btnar_pkg.sv @@
// Shared types and constants for the button autorepeat block.
package btnar_pkg;

	localparam int NumButtons = 12;
	localparam int ButtonW    = 12;
	localparam int AxisW      = 8;
	localparam int TimeW      = 64;
	localparam int TpmW       = 20;
	localparam int MsW        = 16;
	localparam int DelayW     = TpmW + MsW;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 20;

	localparam logic [TpmW-1:0]  TpmReset      = TpmW'(1000);
	localparam logic [MsW-1:0]   InitDlyReset  = MsW'(400);
	localparam logic [MsW-1:0]   RepIntReset   = MsW'(50);
	localparam logic [AxisW-1:0] LowLimReset   = AxisW'(32);
	localparam logic [AxisW-1:0] HighLimReset  = AxisW'(224);

	typedef enum logic [CfgIdxW-1:0] {
		REG_POLLING_MODE    = 3'd0,
		REG_TICKS_PER_MS    = 3'd1,
		REG_INITIAL_DELAY   = 3'd2,
		REG_REPEAT_INTERVAL = 3'd3,
		REG_STICK_LOW       = 3'd4,
		REG_STICK_HIGH      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic              mode;
		logic [DelayW-1:0] init_delay;
		logic [DelayW-1:0] rep_delay;
	} rpt_cfg_t;

	typedef struct packed {
		logic [AxisW-1:0] low;
		logic [AxisW-1:0] high;
	} stick_lim_t;

endpackage

@@ rtl/button_autorepeat_with_stick_directions.sv @@
// Top level: controller sample qualifier with autorepeat and stick directions.
//
// Input channel (in_valid/in_ready) takes one controller sample per beat:
// sample_ok, raw_buttons, stick_x, stick_y and now_ticks. Output channel
// (out_valid/out_ready) gives one result beat per sample: status_ok,
// buttons_out, the stick axes and four direction flags.
// A sample passes from the input register into the output register, where
// its result is held for the output channel.
// Throughput is one sample per cycle while out_ready does not stall the output;
// the per-button deadline compare and add in the input stage set the cycle time.
// When out_ready is low the output register holds and the input register
// fills; in_ready drops only once both are full.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; the tick delays are registered from the written values.
// Reset empties both registers, clears all held flags and loads the
// default register values.
module button_autorepeat_with_stick_directions (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [btnar_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [btnar_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            sample_ok,
	input  logic [btnar_pkg::ButtonW-1:0]   raw_buttons,
	input  logic [btnar_pkg::AxisW-1:0]     stick_x,
	input  logic [btnar_pkg::AxisW-1:0]     stick_y,
	input  logic [btnar_pkg::TimeW-1:0]     now_ticks,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status_ok,
	output logic [btnar_pkg::ButtonW-1:0]   buttons_out,
	output logic [btnar_pkg::AxisW-1:0]     stick_x_out,
	output logic [btnar_pkg::AxisW-1:0]     stick_y_out,
	output logic                            dir_up,
	output logic                            dir_down,
	output logic                            dir_left,
	output logic                            dir_right
);

	btnar_pkg::rpt_cfg_t   rpt_cfg;
	btnar_pkg::stick_lim_t stick_lim;

	logic                          vld_s1;
	logic                          ok_s1;
	logic [btnar_pkg::ButtonW-1:0] raw_s1;
	logic [btnar_pkg::AxisW-1:0]   sx_s1;
	logic [btnar_pkg::AxisW-1:0]   sy_s1;
	logic [btnar_pkg::TimeW-1:0]   now_s1;

	logic                          vld_s2;
	logic                          ok_s2;
	logic [btnar_pkg::ButtonW-1:0] btn_s2;
	logic [btnar_pkg::AxisW-1:0]   sx_s2;
	logic [btnar_pkg::AxisW-1:0]   sy_s2;
	logic                          up_s2;
	logic                          down_s2;
	logic                          left_s2;
	logic                          right_s2;

	logic                          adv;
	logic [btnar_pkg::ButtonW-1:0] btn;
	logic                          up;
	logic                          left;

	btnar_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rpt_cfg   (rpt_cfg),
		.stick_lim (stick_lim)
	);

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ok_s1  <= sample_ok;
			raw_s1 <= raw_buttons;
			sx_s1  <= stick_x;
			sy_s1  <= stick_y;
			now_s1 <= now_ticks;
		end
	end

	btnar_rpt u_rpt (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.ok      (ok_s1),
		.raw     (raw_s1),
		.now     (now_s1),
		.rpt_cfg (rpt_cfg),
		.btn     (btn)
	);

	assign up   = sy_s1 < stick_lim.low;
	assign left = sx_s1 < stick_lim.low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || out_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2    <= ok_s1;
			btn_s2   <= ok_s1 ? btn : '0;
			sx_s2    <= ok_s1 ? sx_s1 : '0;
			sy_s2    <= ok_s1 ? sy_s1 : '0;
			up_s2    <= ok_s1 && up;
			down_s2  <= ok_s1 && !up && (sy_s1 >= stick_lim.high);
			left_s2  <= ok_s1 && left;
			right_s2 <= ok_s1 && !left && (sx_s1 >= stick_lim.high);
		end
	end

	assign out_valid   = vld_s2;
	assign status_ok   = ok_s2;
	assign buttons_out = btn_s2;
	assign stick_x_out = sx_s2;
	assign stick_y_out = sy_s2;
	assign dir_up      = up_s2;
	assign dir_down    = down_s2;
	assign dir_left    = left_s2;
	assign dir_right   = right_s2;

endmodule

@@ rtl/btnar_cfg.sv @@
// Configuration registers and precomputed repeat delays in ticks.
module btnar_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [btnar_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [btnar_pkg::CfgDataW-1:0]  cfg_data,
	output btnar_pkg::rpt_cfg_t             rpt_cfg,
	output btnar_pkg::stick_lim_t           stick_lim
);

	logic                         mode_q;
	logic [btnar_pkg::TpmW-1:0]   tpm_q;
	logic [btnar_pkg::MsW-1:0]    init_ms_q;
	logic [btnar_pkg::MsW-1:0]    rep_ms_q;
	logic [btnar_pkg::AxisW-1:0]  low_q;
	logic [btnar_pkg::AxisW-1:0]  high_q;
	logic [btnar_pkg::DelayW-1:0] init_dly_q;
	logic [btnar_pkg::DelayW-1:0] rep_dly_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			tpm_q     <= btnar_pkg::TpmReset;
			init_ms_q <= btnar_pkg::InitDlyReset;
			rep_ms_q  <= btnar_pkg::RepIntReset;
			low_q     <= btnar_pkg::LowLimReset;
			high_q    <= btnar_pkg::HighLimReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (btnar_pkg::cfg_reg_t'(cfg_index))
				btnar_pkg::REG_POLLING_MODE:    mode_q    <= cfg_data[0];
				btnar_pkg::REG_TICKS_PER_MS:    tpm_q     <= cfg_data[btnar_pkg::TpmW-1:0];
				btnar_pkg::REG_INITIAL_DELAY:   init_ms_q <= cfg_data[btnar_pkg::MsW-1:0];
				btnar_pkg::REG_REPEAT_INTERVAL: rep_ms_q  <= cfg_data[btnar_pkg::MsW-1:0];
				btnar_pkg::REG_STICK_LOW:       low_q     <= cfg_data[btnar_pkg::AxisW-1:0];
				btnar_pkg::REG_STICK_HIGH:      high_q    <= cfg_data[btnar_pkg::AxisW-1:0];
				default: ;
			endcase
		end
	end

	// delays in ticks, registered in the cycle after the ms registers change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_dly_q <= btnar_pkg::DelayW'(btnar_pkg::TpmReset) *
				btnar_pkg::DelayW'(btnar_pkg::InitDlyReset);
			rep_dly_q  <= btnar_pkg::DelayW'(btnar_pkg::TpmReset) *
				btnar_pkg::DelayW'(btnar_pkg::RepIntReset);
		end else begin
			init_dly_q <= btnar_pkg::DelayW'(tpm_q) * btnar_pkg::DelayW'(init_ms_q);
			rep_dly_q  <= btnar_pkg::DelayW'(tpm_q) * btnar_pkg::DelayW'(rep_ms_q);
		end
	end

	assign rpt_cfg.mode       = mode_q;
	assign rpt_cfg.init_delay = init_dly_q;
	assign rpt_cfg.rep_delay  = rep_dly_q;
	assign stick_lim.low      = low_q;
	assign stick_lim.high     = high_q;

endmodule

@@ rtl/btnar_rpt.sv @@
// Per-button held flags, deadlines and autorepeat pulse logic.
module btnar_rpt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            ok,
	input  logic [btnar_pkg::ButtonW-1:0]   raw,
	input  logic [btnar_pkg::TimeW-1:0]     now,
	input  btnar_pkg::rpt_cfg_t             rpt_cfg,
	output logic [btnar_pkg::ButtonW-1:0]   btn
);

	logic [btnar_pkg::NumButtons-1:0] held_q;
	logic [btnar_pkg::TimeW-1:0]      fire_q [btnar_pkg::NumButtons];
	logic [btnar_pkg::NumButtons-1:0] pulse;
	logic [btnar_pkg::NumButtons-1:0] due;
	logic [btnar_pkg::TimeW-1:0]      fire_d [btnar_pkg::NumButtons];
	logic                             upd;

	assign upd = step && ok && rpt_cfg.mode;

	always_comb begin
		btn = '0;
		for (int i = 0; i < btnar_pkg::NumButtons; i++) begin
			due[i]    = now >= fire_q[i];
			pulse[i]  = raw[i] && (!held_q[i] || due[i]);
			fire_d[i] = now + btnar_pkg::TimeW'(held_q[i] ? rpt_cfg.rep_delay
				: rpt_cfg.init_delay);
			btn[i]    = rpt_cfg.mode ? pulse[i] : raw[i];
		end
		if (!rpt_cfg.mode) begin
			btn = raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (upd) begin
			held_q <= raw[btnar_pkg::NumButtons-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < btnar_pkg::NumButtons; i++) begin
			if (upd && pulse[i]) begin
				fire_q[i] <= fire_d[i];
			end
		end
	end

endmodule
